// ----- rtl/core/ipv4_reassembly_context_table_macros.svh -----
// Assertion macros for the reassembly context table.
`ifndef IPV4_REASSEMBLY_CONTEXT_TABLE_MACROS_SVH
`define IPV4_REASSEMBLY_CONTEXT_TABLE_MACROS_SVH
`ifndef SYNTH
`define IRCT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("lbl");
`define IRCT_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("lbl");
`else
`define IRCT_ASSERT(lbl, clk, rstn, prop)
`define IRCT_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- rtl/core/irct_pkg.sv -----
// Package with types and constants of the reassembly context table.
`timescale 1ns / 1ps
package irct_pkg;
  localparam int unsigned SlotsDef = 8;
  localparam int unsigned MaxDatagramDef = 65535;
  localparam logic [16:0] RxMax = 17'h1FFFF;
  localparam logic [5:0] HdrMin = 6'd20;

  localparam logic [1:0] CfgTimeout = 2'd0;
  localparam logic [1:0] CfgMinFrag = 2'd1;
  localparam logic [1:0] CfgOutLimit = 2'd2;

  localparam logic [2:0] StStored = 3'd0;
  localparam logic [2:0] StComplete = 3'd1;
  localparam logic [2:0] StMalformed = 3'd2;
  localparam logic [2:0] StTooSmall = 3'd3;
  localparam logic [2:0] StFull = 3'd4;
  localparam logic [2:0] StTooLarge = 3'd5;
  localparam logic [2:0] StOverLimit = 3'd6;

  // One slot record as held in memory; validity lives in flip-flops.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ident;
    logic [16:0] rx_bytes;
    logic [16:0] final_len;
    logic        last_seen;
    logic [31:0] created;
  } slot_rec_t;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StScan  = 6'b000010,
    StCheck = 6'b000100,
    StWrite = 6'b001000,
    StTick  = 6'b010000,
    StDone  = 6'b100000
  } fsm_e;
endpackage

// ----- rtl/core/irct_slot_mem.sv -----
// Slot record memory, one write and one registered read port.
`timescale 1ns / 1ps
module irct_slot_mem import irct_pkg::*; #(
  parameter int unsigned Slots = SlotsDef,
  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  slot_rec_t       wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output slot_rec_t       rdata_o
);
  slot_rec_t mem_q [Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/ipv4_reassembly_context_table.sv -----
// Top level: IPv4 fragment reassembly slot table with sequencer.
// Fragment request: the table is scanned, StCheck checks and writes back the record,
// and StDone raises the strobe through a register, with the result on the outputs.
// Tick request: the table is scanned one record per cycle, then the strobe is raised.
// busy falls in the cycle after the strobe; no new request is taken while busy, and
// the receiver cannot stall. Reset clears valid bits and seconds, sets default config.
`timescale 1ns / 1ps
`include "ipv4_reassembly_context_table_macros.svh"
module ipv4_reassembly_context_table import irct_pkg::*; #(
  parameter int unsigned Slots = SlotsDef,
  parameter int unsigned MaxDatagram = MaxDatagramDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        action_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] ident_i,
  input  logic [12:0] offset_units_i,
  input  logic        more_fragments_i,
  input  logic [5:0]  header_len_i,
  input  logic [15:0] total_length_i,
  input  logic [15:0] captured_length_i,
  output logic [2:0]  status_o,
  output logic [2:0]  slot_o,
  output logic        new_entry_o,
  output logic [16:0] write_offset_o,
  output logic [15:0] copy_length_o,
  output logic [16:0] datagram_length_o,
  output logic [7:0]  expired_mask_o
);
  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam logic [CW-1:0] LastIdx = CW'(Slots - 1);

  logic [7:0]  tmo_q;
  logic [10:0] minf_q;
  logic [15:0] olim_q;
  logic [31:0] now_q, now_d;
  logic [Slots-1:0] valid_q, valid_d;
  fsm_e state_q, state_d;

  logic        act_q, mf_q;
  logic [31:0] src_q, dst_q;
  logic [15:0] id_q;
  logic [15:0] tl_q, cap_q;
  logic [12:0] off_q;
  logic [5:0]  hl_q;

  logic [CW-1:0] ridx_q, ridx_d;  // read address
  logic [CW-1:0] cidx_q, cidx_d;  // index of record now on rdata
  logic          rd_vld_q, rd_vld_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  slot_rec_t     hit_rec_q, hit_rec_d;
  logic [7:0]    mask_q, mask_d;

  logic [2:0]  st_q, st_d;
  logic [2:0]  so_q, so_d;
  logic        ne_q, ne_d;
  logic [16:0] wo_q, wo_d, dl_q, dl_d;
  logic [15:0] cl_q, cl_d;
  logic        done_q, done_d;

  logic          we;
  logic [AW-1:0] waddr;
  slot_rec_t     wdata, rdata;

  irct_slot_mem #(.Slots(Slots)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ridx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Lowest free slot.
  logic          free_any;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic [15:0] payload;
  logic [16:0] off_b, end_b;
  logic        malformed;
  assign payload   = tl_q - {10'd0, hl_q};
  assign off_b     = {1'b0, off_q, 3'd0};
  assign end_b     = off_b + {1'b0, payload};
  assign malformed = (cap_q < 16'(HdrMin)) || (hl_q < HdrMin) ||
                     (tl_q < {10'd0, hl_q}) || (cap_q < tl_q);

  slot_rec_t   cur;
  logic [17:0] rx_sum;
  logic [16:0] rx_new, fl_new, total;
  logic        ls_new;
  always_comb begin
    cur = hit_rec_q;
    if (!hit_q) begin
      cur.src = src_q;
      cur.dst = dst_q;
      cur.ident = id_q;
      cur.rx_bytes = '0;
      cur.final_len = '0;
      cur.last_seen = 1'b0;
      cur.created = now_q;
    end
    rx_sum = {1'b0, cur.rx_bytes} + {2'd0, payload};
    rx_new = rx_sum[17] ? RxMax : rx_sum[16:0];
    fl_new = mf_q ? cur.final_len : end_b;
    ls_new = cur.last_seen | ~mf_q;
    total  = {11'd0, hl_q} + fl_new;
  end

  logic [AW-1:0] use_idx;
  assign use_idx = hit_q ? hit_idx_q : free_idx;

  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    valid_d   = valid_q;
    ridx_d    = ridx_q;
    cidx_d    = cidx_q;
    rd_vld_d  = 1'b0;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    hit_rec_d = hit_rec_q;
    mask_d    = mask_q;
    st_d = st_q; so_d = so_q; ne_d = ne_q; wo_d = wo_q; cl_d = cl_q; dl_d = dl_q;
    done_d    = 1'b0;
    we        = 1'b0;
    waddr     = use_idx;
    wdata     = cur;
    case (state_q)
      StIdle: begin
        if (start) begin
          ridx_d = '0;
          hit_d  = 1'b0;
          mask_d = '0;
          if (action_i) begin
            now_d   = now_q + 32'd1;
            state_d = StTick;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan, StTick: begin
        if (ridx_q <= LastIdx) begin
          cidx_d   = ridx_q;
          rd_vld_d = 1'b1;
          ridx_d   = ridx_q + CW'(1);
        end
        if (rd_vld_q) begin
          if (state_q == StScan) begin
            if (!hit_q && valid_q[cidx_q[AW-1:0]] && rdata.src == src_q &&
                rdata.dst == dst_q && rdata.ident == id_q) begin
              hit_d     = 1'b1;
              hit_idx_d = cidx_q[AW-1:0];
              hit_rec_d = rdata;
            end
          end else if (valid_q[cidx_q[AW-1:0]] &&
                       (now_q - rdata.created) >= {24'd0, tmo_q}) begin
            valid_d[cidx_q[AW-1:0]] = 1'b0;
            mask_d[cidx_q[AW-1:0]]  = 1'b1;
          end
          if (cidx_q == LastIdx) begin
            state_d = (state_q == StScan) ? StCheck : StDone;
          end
        end
        if (state_q == StTick && state_d == StDone) begin
          st_d = StStored; so_d = '0; ne_d = 1'b0; wo_d = '0; cl_d = '0; dl_d = '0;
        end
      end
      StCheck: begin
        state_d = StDone;
        so_d = '0; ne_d = 1'b0; wo_d = '0; cl_d = '0; dl_d = '0;
        if (malformed) begin
          st_d = StMalformed;
        end else if (mf_q && tl_q < {5'd0, minf_q}) begin
          st_d = StTooSmall;
        end else if (!hit_q && !free_any) begin
          st_d = StFull;
        end else begin
          so_d = 3'(use_idx);
          if (end_b > 17'(MaxDatagram)) begin
            st_d = StTooLarge;
            valid_d[use_idx] = 1'b0;
          end else begin
            wdata.rx_bytes  = rx_new;
            wdata.final_len = fl_new;
            wdata.last_seen = ls_new;
            we = 1'b1;
            if (ls_new && rx_new >= fl_new) begin
              valid_d[use_idx] = 1'b0;
              if (total > {1'b0, olim_q}) begin
                st_d = StOverLimit;
              end else begin
                st_d = StComplete; ne_d = ~hit_q; wo_d = {11'd0, hl_q} + off_b;
                cl_d = payload; dl_d = total;
              end
            end else begin
              valid_d[use_idx] = 1'b1;
              st_d = StStored; ne_d = ~hit_q; wo_d = {11'd0, hl_q} + off_b;
              cl_d = payload;
            end
          end
        end
      end
      StDone: begin
        done_d  = 1'b1;
        state_d = StWrite;
      end
      StWrite: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      tmo_q    <= 8'd30;
      minf_q   <= 11'd68;
      olim_q   <= 16'hFFFF;
      now_q    <= '0;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      ridx_q   <= '0;
      cidx_q   <= '0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      valid_q  <= valid_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
      ridx_q   <= ridx_d;
      cidx_q   <= cidx_d;
      hit_q    <= hit_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTimeout:  tmo_q  <= cfg_data_i[7:0];
          CfgMinFrag:  minf_q <= cfg_data_i[10:0];
          CfgOutLimit: olim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      act_q <= action_i; src_q <= src_addr_i; dst_q <= dst_addr_i; id_q <= ident_i;
      off_q <= offset_units_i; mf_q <= more_fragments_i; hl_q <= header_len_i;
      tl_q <= total_length_i; cap_q <= captured_length_i;
    end
    hit_idx_q <= hit_idx_d;
    hit_rec_q <= hit_rec_d;
    mask_q    <= mask_d;
    st_q <= st_d; so_q <= so_d; ne_q <= ne_d; wo_q <= wo_d; cl_q <= cl_d; dl_q <= dl_d;
  end

  assign busy              = (state_q != StIdle);
  assign done_o            = done_q;
  assign status_o          = st_q;
  assign slot_o            = so_q;
  assign new_entry_o       = ne_q;
  assign write_offset_o    = wo_q;
  assign copy_length_o     = cl_q;
  assign datagram_length_o = dl_q;
  assign expired_mask_o    = act_q ? mask_q : 8'd0;

  `IRCT_ASSERT(a_done_one, clk_i, rst_ni, done_q |=> !done_q)
  `IRCT_ASSERT(a_done_busy, clk_i, rst_ni, done_q |-> busy)
  `IRCT_ASSERT(a_tick_mask, clk_i, rst_ni, (done_q && !act_q) |-> (expired_mask_o == 8'd0))
  `IRCT_ASSERT_NEVER(a_done_idle, clk_i, rst_ni, done_q && (state_q == StIdle))
endmodule
